[rtl/rwh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling window hash package
// Field widths and hash constants shared by the channel interfaces and the
// top level.
// ----------------------------------------------------------------------------
package rwh_pkg;

   localparam int SYM_W          = 8;
   localparam int HASH_W         = 17;
   localparam int POS_W          = 32;
   localparam int LEN_W          = 7;

   localparam int MAX_WINDOW_DEF = 64;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd10;

   // base 256 is a left shift by eight
   localparam int HASH_MOD       = 99991;
   localparam int BASE_SHIFT     = 8;

   // result queue depth, covers the pipeline in flight plus stalled words
   localparam int FIFO_DEPTH     = 8;

endpackage

[rtl/rwh_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbol request channel
// Valid/ready channel carrying one symbol byte and its restart flag.
// ----------------------------------------------------------------------------
interface rwh_req_if;
   import rwh_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             restart;

   modport source (output valid, output symbol, output restart, input ready);
   modport sink   (input valid, input symbol, input restart, output ready);

endinterface

[rtl/rwh_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash response channel
// Valid/ready channel carrying one window hash and the window start position.
// ----------------------------------------------------------------------------
interface rwh_rsp_if;
   import rwh_pkg::*;

   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] window_hash;
   logic [POS_W-1:0]  window_start;

   modport source (output valid, output window_hash, output window_start, input ready);
   modport sink   (input valid, input window_hash, input window_start, output ready);

endinterface

[rtl/rwh_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window length register write channel
// Valid/ready channel carrying the write data of the window length register.
// ----------------------------------------------------------------------------
interface rwh_csr_if;
   import rwh_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);

endinterface

[rtl/rolling_window_hash_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling window hash, top level
// Rabin-Karp hash (base 256, modulo 99991) over a sliding window of symbols.
// ----------------------------------------------------------------------------
// The block takes one symbol word per clock and, once the window holds
// window_length symbols, returns one word per symbol with the window hash and
// the position of the window's first symbol. A symbol goes through window
// read, weight multiply, drop reduction and hash update, then waits in an
// eight-word result queue, so the input keeps streaming while results are
// held back; the input stalls when the queue and the words in flight would
// fill it. Sustained rate is one symbol per cycle while the hash side keeps
// taking words, set by the hash feedback loop. After reset and after each
// write of window_length, the leading weight 256^L mod 99991 is built by one
// multiply-by-256 step per cycle, and req_bus.ready stays low until it is
// complete. A length of 0 acts as 1 and a length above MAX_WINDOW acts as
// MAX_WINDOW; a length write empties the window but keeps the position count.
// ----------------------------------------------------------------------------
module rolling_window_hash_top #(
   parameter int MAX_WINDOW = rwh_pkg::MAX_WINDOW_DEF
) (
   input logic        clock,
   input logic        reset,
   rwh_req_if.sink    req_bus,
   rwh_rsp_if.source  rsp_bus,
   rwh_csr_if.sink    csr_bus
);
   import rwh_pkg::*;

   localparam int AW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int MAX_CAP     = (1 << LEN_W) - 1;
   localparam logic [LEN_W-1:0] MAX_LEN =
      LEN_W'((MAX_WINDOW > MAX_CAP) ? MAX_CAP : MAX_WINDOW);
   localparam int PW          = ((AW > LEN_W) ? AW : LEN_W) + 1;
   localparam int RED_W       = HASH_W + BASE_SHIFT;
   localparam int RECIP       = (1 << RED_W) / HASH_MOD;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int OCC_W       = FIFO_AW + 2;
   localparam logic [HASH_W:0]   MOD_R = (HASH_W + 1)'(HASH_MOD);

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             restart;
      logic             full;
      logic             emit;
      logic [POS_W-1:0] start;
   } stage_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [POS_W-1:0]  start;
   } rsp_word_type;

   // x mod 99991 for x below 2^25: reciprocal estimate, then one correction
   function automatic logic [HASH_W-1:0] mod_reduce(input logic [RED_W-1:0] x);
      logic [RED_W+RECIP_W-1:0] prod;
      logic [RECIP_W-1:0]       q;
      logic [RED_W-1:0]         qm;
      logic [HASH_W:0]          r;
      prod = (RED_W + RECIP_W)'(x) * (RED_W + RECIP_W)'(RECIP);
      q    = prod[RED_W+RECIP_W-1:RED_W];
      qm   = RED_W'(q) * RED_W'(HASH_MOD);
      r    = (HASH_W + 1)'(x - qm);
      if (r >= MOD_R) begin
         return HASH_W'(r - MOD_R);
      end
      return HASH_W'(r);
   endfunction

   // configuration and leading weight
   logic [LEN_W-1:0]  wl_ff;
   logic [LEN_W-1:0]  len;
   logic              busy_ff;
   logic [LEN_W-1:0]  wcnt_ff;
   logic [HASH_W-1:0] lead_ff;

   // stream state
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [SYM_W-1:0]  window_mem [MAX_WINDOW];
   logic [AW-1:0]     rd_addr;

   // pipeline
   stage_type         a_ff, b_ff, c_ff, a_in;
   logic              va_ff, vb_ff, vc_ff;
   logic [SYM_W-1:0]  oldest_ff;
   logic [RED_W-1:0]  prod_ff;
   logic [HASH_W-1:0] drop_ff;

   // result queue
   rsp_word_type      fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]  cnt_ff;
   logic [OCC_W-1:0]  occ;

   logic req_fire, rsp_fire, csr_fire, push;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (wl_ff == '0) begin
         len = LEN_W'(1);
      end else if (wl_ff > MAX_LEN) begin
         len = MAX_LEN;
      end else begin
         len = wl_ff;
      end
   end

   // leading weight 256^L mod 99991, one base step per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= LEN_RESET;
         busy_ff <= 1'b1;
         wcnt_ff <= '0;
         lead_ff <= HASH_W'(1);
      end else if (csr_fire) begin
         wl_ff   <= csr_bus.window_length;
         busy_ff <= 1'b1;
         wcnt_ff <= '0;
         lead_ff <= HASH_W'(1);
      end else if (busy_ff) begin
         if (wcnt_ff == len) begin
            busy_ff <= 1'b0;
         end else begin
            lead_ff <= mod_reduce({lead_ff, {BASE_SHIFT{1'b0}}});
            wcnt_ff <= wcnt_ff + LEN_W'(1);
         end
      end
   end

   // admission: fill, position and window start
   always_comb begin
      logic [LEN_W-1:0] fill_base;
      logic [POS_W-1:0] pos_base;
      fill_base    = req_bus.restart ? '0 : fill_ff;
      pos_base     = req_bus.restart ? '0 : pos_ff;
      a_in.sym     = req_bus.symbol;
      a_in.restart = req_bus.restart;
      a_in.full    = (fill_base >= len);
      fill_in      = a_in.full ? fill_base : fill_base + LEN_W'(1);
      a_in.emit    = (fill_in >= len);
      pos_in       = pos_base + POS_W'(1);
      a_in.start   = pos_in - POS_W'(len);
      wp_in        = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
   end

   // oldest symbol sits L entries behind the write pointer
   always_comb begin
      logic [PW-1:0] wp_w, len_w;
      wp_w  = PW'(wp_ff);
      len_w = PW'(len);
      if (wp_w >= len_w) begin
         rd_addr = AW'(wp_w - len_w);
      end else begin
         rd_addr = AW'(wp_w + PW'(MAX_WINDOW) - len_w);
      end
   end

   // read before write: at full length the oldest entry is the one replaced
   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_mem[wp_ff] <= req_bus.symbol;
         oldest_ff         <= window_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
         wp_ff   <= '0;
      end else if (csr_fire) begin
         fill_ff <= '0;
      end else if (req_fire) begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         wp_ff   <= wp_in;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= req_fire;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   // pipeline payload: multiply, then reduce the drop term
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= a_ff;
      c_ff    <= b_ff;
      prod_ff <= RED_W'(oldest_ff) * RED_W'(lead_ff);
      drop_ff <= mod_reduce(prod_ff);
   end

   // hash update: 256*h + sym, then remove oldest*256^L
   always_comb begin
      logic [HASH_W-1:0] h_base;
      logic [HASH_W-1:0] t;
      h_base = c_ff.restart ? '0 : hash_ff;
      t      = mod_reduce({h_base, c_ff.sym});
      if (!c_ff.full) begin
         hash_in = t;
      end else if (t >= drop_ff) begin
         hash_in = t - drop_ff;
      end else begin
         hash_in = HASH_W'((HASH_W + 1)'(t) + MOD_R - (HASH_W + 1)'(drop_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else if (csr_fire) begin
         hash_ff <= '0;
      end else if (vc_ff) begin
         hash_ff <= hash_in;
      end
   end

   // result queue
   assign push = vc_ff && c_ff.emit;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= '{hash: hash_in, start: c_ff.start};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         case ({push, rsp_fire})
            2'b10:   cnt_ff <= cnt_ff + (FIFO_AW + 1)'(1);
            2'b01:   cnt_ff <= cnt_ff - (FIFO_AW + 1)'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // hold input while queue plus words in flight could overflow
   assign occ = OCC_W'(cnt_ff) + OCC_W'(va_ff) + OCC_W'(vb_ff) + OCC_W'(vc_ff);
   assign req_bus.ready = !busy_ff && (occ < OCC_W'(FIFO_DEPTH));

   assign rsp_bus.valid        = (cnt_ff != '0);
   assign rsp_bus.window_hash  = fifo_mem[rd_ptr_ff].hash;
   assign rsp_bus.window_start = fifo_mem[rd_ptr_ff].start;

endmodule

[verif/rwh_hash_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling window hash checker
// Watches the symbol, length and hash channels. It keeps its own window,
// running hash and position, predicts every hash word, and compares each
// returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rwh_hash_checker (
   input  logic clock,
   input  logic reset,
   rwh_req_if   req_mon,
   rwh_rsp_if   rsp_mon,
   rwh_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_words,
   output int   symbols_seen,
   output int   words_checked,
   output int   writes_seen
);
   import rwh_pkg::*;

   localparam int WIN_AW = $clog2(MAX_WINDOW_DEF);

   typedef struct packed {
      logic [HASH_W-1:0] window_hash;
      logic [POS_W-1:0]  window_start;
   } hash_word_type;

   hash_word_type    hash_fifo[$];
   logic [SYM_W-1:0] sym_window [MAX_WINDOW_DEF];
   logic [LEN_W-1:0] length_reg;
   logic [POS_W-1:0] next_pos;
   int unsigned      sum_hash;
   int unsigned      fill;
   int unsigned      weight;
   int               errs, syms, words, writes;

   // zero acts as one, anything above the store depth acts as the depth
   function automatic int unsigned used_length(input logic [LEN_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return raw;
   endfunction

   // 256^(len-1) mod the hash modulus, the weight of the oldest symbol
   function automatic int unsigned lead_weight(input int unsigned len);
      int unsigned w;
      w = 1;
      for (int i = 1; i < len; i++) w = (w << BASE_SHIFT) % HASH_MOD;
      return w;
   endfunction

   task automatic hash_symbol(input logic [SYM_W-1:0] sym, input logic restart);
      int unsigned   len;
      int unsigned   drop;
      hash_word_type word;
      len = used_length(length_reg);
      if (restart) begin
         fill     = 0;
         sum_hash = 0;
         next_pos = '0;
      end
      if (fill < len) begin
         sym_window[WIN_AW'(fill)] = sym;
         fill++;
         sum_hash = ((sum_hash << BASE_SHIFT) + sym) % HASH_MOD;
      end else begin
         // drop the oldest symbol, shift the window, append the new one
         drop = (sym_window[0] * weight) % HASH_MOD;
         for (int i = 0; i + 1 < len; i++) begin
            sym_window[WIN_AW'(i)] = sym_window[WIN_AW'(i + 1)];
         end
         sym_window[WIN_AW'(len - 1)] = sym;
         sum_hash = (((sum_hash + HASH_MOD - drop) << BASE_SHIFT) + sym) % HASH_MOD;
      end
      next_pos++;
      if (fill >= len) begin
         word.window_hash  = sum_hash[HASH_W-1:0];
         word.window_start = next_pos - len;
         hash_fifo = {hash_fifo, word};
      end
   endtask

   always @(posedge clock) begin
      hash_word_type want;
      if (reset) begin
         hash_fifo.delete();
         length_reg = LEN_RESET;
         weight     = lead_weight(used_length(LEN_RESET));
         fill       = 0;
         sum_hash   = 0;
         next_pos   = '0;
         errs       = 0;
         syms       = 0;
         words      = 0;
         writes     = 0;
      end else begin
         // a length write empties the window but keeps the position
         if (csr_mon.valid && csr_mon.ready) begin
            length_reg = csr_mon.window_length;
            weight     = lead_weight(used_length(length_reg));
            fill       = 0;
            sum_hash   = 0;
            writes++;
         end
         if (req_mon.valid && req_mon.ready) begin
            hash_symbol(req_mon.symbol, req_mon.restart);
            syms++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (hash_fifo.size() == 0) begin
               $error("hash word with none expected: window_hash %0d window_start %0d",
                      rsp_mon.window_hash, rsp_mon.window_start);
               errs++;
            end else begin
               want = hash_fifo.pop_front();
               words++;
               if (rsp_mon.window_hash !== want.window_hash) begin
                  $error("window_hash mismatch: expected %0d, got %0d",
                         want.window_hash, rsp_mon.window_hash);
                  errs++;
               end
               if (rsp_mon.window_start !== want.window_start) begin
                  $error("window_start mismatch: expected %0d, got %0d",
                         want.window_start, rsp_mon.window_start);
                  errs++;
               end
            end
         end
      end
      fail_count    <= errs;
      pending_words <= hash_fifo.size();
      symbols_seen  <= syms;
      words_checked <= words;
      writes_seen   <= writes;
   end

endmodule

[verif/tb_rolling_window_hash_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling window hash testbench
// Streams directed and random symbols through the block over a range of
// window lengths, with random idle cycles on the symbol side and random
// back-pressure on the hash side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_rolling_window_hash_top;
   import rwh_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending_words, symbols_seen, words_checked, writes_seen;
   bit   req_calm, rsp_calm;

   rwh_req_if req_bus ();
   rwh_rsp_if rsp_bus ();
   rwh_csr_if csr_bus ();

   rolling_window_hash_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rwh_hash_checker hash_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .symbols_seen  (symbols_seen),
      .words_checked (words_checked),
      .writes_seen   (writes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_rolling_window_hash_top: errors");
      $finish;
   end

   // hash side: stall a random number of cycles before taking each word
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic restart);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.symbol  <= sym;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // hold the symbol side until every hash word is back and the pipe is empty
   task automatic drain_words();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] value);
      drain_words();
      csr_bus.valid         <= 1'b1;
      csr_bus.window_length <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [LEN_W-1:0] len;
      logic [SYM_W-1:0] sym;
      logic             restart;
      bit               open_restart;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.symbol        <= '0;
      req_bus.restart       <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.window_length <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset length of ten: fill, slide over extremes, restart mid-window
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h80, 1'b0);
      send_symbol(8'h01, 1'b0);
      send_symbol(8'h7F, 1'b0);
      send_symbol(8'hFE, 1'b0);
      send_symbol(8'h55, 1'b0);
      send_symbol(8'hAA, 1'b0);
      send_symbol(8'h02, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b1);
      repeat (9) send_symbol(8'hFF, 1'b0);

      // length phases: one, zero (acts as one), full store, all ones, two, just
      // over the store, then mostly short random lengths
      for (int p = 0; p < 12; p++) begin
         case (p)
            0:       len = 7'd1;
            1:       len = 7'd0;
            2:       len = 7'd64;
            3:       len = 7'd127;
            4:       len = 7'd2;
            5:       len = 7'd65;
            default: len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 127))
                                                       : LEN_W'($urandom_range(1, 16));
         endcase
         write_length(len);
         // without a restart the position keeps counting across the write
         open_restart = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 130; n++) begin
            if ($urandom_range(0, 7) == 0) sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else sym = SYM_W'($urandom_range(0, 255));
            restart = (n == 0 && open_restart) || ($urandom_range(0, 59) == 0);
            send_symbol(sym, restart);
         end
      end

      drain_words();
      $display("covered %0d symbols and %0d hash words over %0d window length writes",
               symbols_seen, words_checked, writes_seen);
      $display("lengths 0, 1, 2, 64, 65, 127 and random, with restarts and stalls");
      if (fail_count == 0 && pending_words == 0) begin
         $display("tb_rolling_window_hash_top: clean");
      end else begin
         $display("tb_rolling_window_hash_top: errors");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rwh_pkg.sv
rtl/rwh_req_if.sv
rtl/rwh_rsp_if.sv
rtl/rwh_csr_if.sv
rtl/rolling_window_hash_top.sv
verif/rwh_hash_checker.sv
verif/tb_rolling_window_hash_top.sv
